FILE: hw/rtl/bfr_pkg.sv
package bfr_pkg;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_KERNEL = 2'd2;

    localparam logic [7:0] ID_CHECK_SEC = 8'h90;
    localparam logic [7:0] ID_DOWNLOAD  = 8'h12;
    localparam logic [7:0] ID_LOCK      = 8'h0c;
    localparam logic [7:0] ID_JUMP      = 8'h9f;
    localparam logic [7:0] ID_UNLOCK    = 8'h0a;

    localparam logic [1:0] CFG_SEED    = 2'd0;
    localparam logic [1:0] CFG_SECURED = 2'd1;
    localparam logic [1:0] CFG_OK      = 2'd2;

    localparam logic [7:0] SEED_RESET    = 8'h00;
    localparam logic [7:0] SECURED_RESET = 8'h96;
    localparam logic [7:0] OK_RESET      = 8'h69;

    // kernel body length when the length byte is zero
    localparam logic [8:0] KERNEL_MAX_LEN = 9'd257;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] current_id;
        logic [8:0] bytes_left;
        logic [7:0] running_sum;
        logic [7:0] kernel_len;
    } t_state;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       checksum_error;
        logic       frame_done;
    } t_result;

    typedef struct packed {
        logic [7:0] seed;
        logic [7:0] secured_reply;
        logic [7:0] ok_reply;
        logic       seed_load;
    } t_cfg;

    function automatic logic [8:0] body_length(input logic [7:0] id);
        logic [8:0] len;
        case (id)
            ID_CHECK_SEC: len = 9'd5;
            ID_DOWNLOAD:  len = 9'd5;
            ID_LOCK:      len = 9'd2;
            ID_JUMP:      len = 9'd4;
            ID_UNLOCK:    len = 9'd18;
            default:      len = 9'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/bfr_cfg_regs.sv
module bfr_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output bfr_pkg::t_cfg  o_cfg
);

    logic [7:0] r_seed;
    logic [7:0] r_secured;
    logic [7:0] r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= bfr_pkg::SEED_RESET;
            r_secured <= bfr_pkg::SECURED_RESET;
            r_ok      <= bfr_pkg::OK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfr_pkg::CFG_SEED:    r_seed    <= i_cfg_data;
                bfr_pkg::CFG_SECURED: r_secured <= i_cfg_data;
                bfr_pkg::CFG_OK:      r_ok      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.seed          = r_seed;
        o_cfg.secured_reply = r_secured;
        o_cfg.ok_reply      = r_ok;
        // seed write also reloads the running sum
        o_cfg.seed_load     = i_cfg_we && (i_cfg_index == bfr_pkg::CFG_SEED);
    end

endmodule

FILE: hw/rtl/bfr_step.sv
module bfr_step (
    input  bfr_pkg::t_state  i_state,
    input  bfr_pkg::t_cfg    i_cfg,
    input  logic [7:0]       i_byte,
    output bfr_pkg::t_state  o_state,
    output bfr_pkg::t_result o_result
);

    logic [8:0] sum_raw;
    logic [7:0] sum_eac;
    logic       last;
    logic [8:0] len;

    always_comb begin
        // end-around carry: fold the carry back into bit 0
        sum_raw = {1'b0, i_state.running_sum} + {1'b0, i_byte};
        sum_eac = sum_raw[7:0] + {7'd0, sum_raw[8]};
        last    = (i_state.bytes_left <= 9'd1);
        len     = bfr_pkg::body_length(i_byte);

        o_state             = i_state;
        o_state.running_sum = sum_eac;
        o_result            = '0;

        if (i_state.phase == bfr_pkg::PH_BODY || i_state.phase == bfr_pkg::PH_KERNEL) begin
            o_result.checksum_error = last && (i_byte != ~i_state.running_sum);
            o_state.bytes_left      = last ? 9'd0 : i_state.bytes_left - 9'd1;
            if (i_state.phase == bfr_pkg::PH_BODY) begin
                if (i_state.current_id == bfr_pkg::ID_DOWNLOAD && i_state.bytes_left == 9'd2) begin
                    o_state.kernel_len = i_byte;
                end
                if (last) begin
                    if (i_state.current_id == bfr_pkg::ID_DOWNLOAD) begin
                        o_state.phase      = bfr_pkg::PH_KERNEL;
                        o_state.bytes_left = (i_state.kernel_len == 8'd0) ?
                                             bfr_pkg::KERNEL_MAX_LEN :
                                             {1'b0, i_state.kernel_len};
                    end else begin
                        o_result.tx_valid   = 1'b1;
                        o_result.tx_byte    = (i_state.current_id == bfr_pkg::ID_CHECK_SEC) ?
                                              i_cfg.secured_reply : i_cfg.ok_reply;
                        o_result.frame_done = 1'b1;
                        o_state.phase       = bfr_pkg::PH_IDLE;
                    end
                end
            end else begin
                if (last) begin
                    o_result.tx_valid   = 1'b1;
                    o_result.tx_byte    = i_cfg.ok_reply;
                    o_result.frame_done = 1'b1;
                    o_state.phase       = bfr_pkg::PH_IDLE;
                end else begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_byte  = i_byte;
                end
            end
        end else begin
            // waiting for an id; a stray phase code lands here as well
            o_state.phase = bfr_pkg::PH_IDLE;
            if (len != 9'd0) begin
                o_state.current_id = i_byte;
                o_state.bytes_left = len;
                o_state.phase      = bfr_pkg::PH_BODY;
            end
        end
    end

endmodule

FILE: hw/rtl/boot_frame_responder_unit.sv
// Boot frame responder: one received byte per input beat, one result beat per
// input beat. A byte is held in the input register, then the frame update runs
// and fills the result register. A new byte is taken every cycle while the
// result side keeps up; the output register holds its beat while i_out_stall
// is high. The running checksum is never cleared between frames; writing the
// CFG_SEED config register reloads it. Configure only while no beat is in
// flight.
module boot_frame_responder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_checksum_error,
    output logic       o_frame_done
);

    bfr_pkg::t_cfg    cfg;
    bfr_pkg::t_state  r_state;
    bfr_pkg::t_state  n_state;
    bfr_pkg::t_result n_res;
    bfr_pkg::t_result r_res;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_out_valid;
    logic       s1_go;
    logic       in_take;

    bfr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bfr_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_byte   (r_s1_byte),
        .o_state  (n_state),
        .o_result (n_res)
    );

    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= bfr_pkg::PH_IDLE;
            r_state.current_id  <= 8'd0;
            r_state.bytes_left  <= 9'd0;
            r_state.running_sum <= bfr_pkg::SEED_RESET;
            r_state.kernel_len  <= 8'd0;
        end else if (cfg.seed_load) begin
            r_state.running_sum <= i_cfg_data;
        end else if (s1_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tx_valid       = r_res.tx_valid;
    assign o_tx_byte        = r_res.tx_byte;
    assign o_payload_valid  = r_res.payload_valid;
    assign o_payload_byte   = r_res.payload_byte;
    assign o_checksum_error = r_res.checksum_error;
    assign o_frame_done     = r_res.frame_done;

    a_reply_xor_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.tx_valid && r_res.payload_valid))
        else $error("reply and payload in one beat");

    a_done_has_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.frame_done) |-> r_res.tx_valid)
        else $error("frame done without reply");

    a_body_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == bfr_pkg::PH_BODY || r_state.phase == bfr_pkg::PH_KERNEL)
        |-> (r_state.bytes_left != 9'd0))
        else $error("body phase with no bytes left");

    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !(r_out_valid && i_out_stall)) |=> r_out_valid)
        else $error("input stage did not move to result");

endmodule
